// ===== hw/rtl/i2c_mra_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, codes and line-phase helpers for the register access master.
// ----------------------------------------------------------------------------
package i2c_mra_pkg;

  // Request class decoded by the front end.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SUPPLY = 2'd3
  } cmd_e;

  // Transaction completion status.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUS_BUSY  = 2'd1,
    STAT_ADDR_NACK = 2'd2,
    STAT_DATA_NACK = 2'd3
  } status_e;

  // Bus sequencer steps.
  typedef enum logic [3:0] {
    STEP_IDLE      = 4'd0,
    STEP_START     = 4'd1,
    STEP_ADDR      = 4'd2,
    STEP_ADDR_ACK  = 4'd3,
    STEP_REG       = 4'd4,
    STEP_REG_ACK   = 4'd5,
    STEP_DATA      = 4'd6,
    STEP_DATA_ACK  = 4'd7,
    STEP_RADDR     = 4'd8,
    STEP_RADDR_ACK = 4'd9,
    STEP_NEED      = 4'd10,
    STEP_RSTART    = 4'd11,
    STEP_RECV      = 4'd12,
    STEP_RACK      = 4'd13,
    STEP_STOP      = 4'd14
  } step_e;

  // One classified word held between the front end and the sequencer.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // Line drives and shifter after a phase begins.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } drive_t;

  // Registered result word.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_byte;
    logic       busy_res;
    logic       done_res;
    status_e    status;
  } res_t;

  // True when the given phase is the last one of its step.
  function automatic logic phase_last(step_e st, logic [1:0] ph);
    logic res;
    unique case (st) inside
      STEP_RECV:            res = (ph >= 2'd1);
      STEP_RACK, STEP_STOP: res = (ph == 2'd3);
      default:              res = (ph >= 2'd2);
    endcase
    return res;
  endfunction

  // Line drives set on the first tick of a phase.
  function automatic drive_t apply_phase(step_e st, logic [1:0] ph, logic [7:0] shift,
                                         logic [7:0] bytes_left, logic scl, logic sda);
    drive_t r;
    r.scl   = scl;
    r.sda   = sda;
    r.shift = shift;
    unique case (st) inside
      STEP_START, STEP_RSTART: begin
        if (ph == 2'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b1;
        end else begin
          r.sda = 1'b0;
        end
      end
      STEP_ADDR, STEP_REG, STEP_DATA, STEP_RADDR: begin
        if (ph == 2'd0) begin
          r.scl = 1'b0;
        end else if (ph == 2'd1) begin
          r.sda   = shift[7];
          r.shift = {shift[6:0], 1'b0};
        end else begin
          r.scl = 1'b1;
        end
      end
      STEP_ADDR_ACK, STEP_REG_ACK, STEP_DATA_ACK, STEP_RADDR_ACK: begin
        if (ph == 2'd0) begin
          r.scl = 1'b0;
        end else if (ph == 2'd1) begin
          r.sda = 1'b1;
        end else begin
          r.scl = 1'b1;
        end
      end
      STEP_RECV: begin
        if (ph == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else begin
          r.scl = 1'b1;
        end
      end
      STEP_RACK: begin
        if (ph == 2'd0) begin
          r.scl = 1'b0;
        end else if (ph == 2'd1) begin
          r.sda = (bytes_left == 8'd1);
        end else if (ph == 2'd2) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      STEP_STOP: begin
        if (ph == 2'd0) begin
          r.scl = 1'b0;
        end else if (ph == 2'd1) begin
          r.sda = 1'b0;
        end else if (ph == 2'd2) begin
          r.scl = 1'b1;
        end else begin
          r.sda = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/i2c_mra_if.sv =====
// ----------------------------------------------------------------------------
// I2C master register access channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------

// Request channel: one word per bus tick.
interface i2c_mra_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] write_byte;
  logic       sda_in;

  modport source (
    output valid, req_type, dev_addr, reg_addr, byte_count, write_byte, sda_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, dev_addr, reg_addr, byte_count, write_byte, sda_in,
    output ready
  );
endinterface

// Result channel: one word per bus tick.
interface i2c_mra_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       need_byte;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (
    output valid, scl_out, sda_out, read_byte, read_valid, need_byte, busy_res,
           done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_out, sda_out, read_byte, read_valid, need_byte, busy_res,
           done_res, status,
    output ready
  );
endinterface

// ===== hw/rtl/i2c_mra_front.sv =====
// ----------------------------------------------------------------------------
// I2C master register access front end
// Accepts request words, classifies them and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module i2c_mra_front
  import i2c_mra_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  i2c_mra_req_if.sink  req_i,
  output logic         item_valid_o,
  input  logic         item_ready_i,
  output item_t        item_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;
  item_t       item_in;

  // Classify the incoming word.
  always_comb begin
    item_in.cmd        = cmd_e'(req_i.req_type);
    item_in.dev_addr   = req_i.dev_addr;
    item_in.reg_addr   = req_i.reg_addr;
    item_in.byte_count = req_i.byte_count;
    item_in.write_byte = req_i.write_byte;
    item_in.sda_in     = req_i.sda_in;
  end

  // Queue handshakes.
  assign req_i.ready  = (cnt_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== hw/rtl/i2c_mra_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master register access sequencer
// Runs one bus tick per queued word and registers the resulting line drives.
// ----------------------------------------------------------------------------
module i2c_mra_engine
  import i2c_mra_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  item_t          item_i,
  i2c_mra_res_if.source  res_o
);

  logic [15:0] phase_ticks_q;
  step_e       st_q, st_d;
  logic [1:0]  ph_q, ph_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bits_q, bits_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  bytes_q, bytes_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic        is_read_q, is_read_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  status_e     pend_q, pend_d;
  res_t        res_q, res_d;
  logic        res_valid_q;

  logic        fire;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [3:0]  bits_inc;
  logic        last;
  logic        enter_en;
  step_e       enter_st;
  logic        begin_en;
  logic [1:0]  begin_ph;
  logic        apply;
  drive_t      drv;
  logic        done;
  logic        rvalid;
  logic [7:0]  rbyte;
  status_e     stat;

  // A word is executed when the result register is free or being drained.
  assign fire         = item_valid_i && (!res_valid_q || res_o.ready);
  assign item_ready_o = fire;
  assign limit        = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
  assign tick_inc     = tick_q + 16'd1;
  assign bits_inc     = bits_q + 4'd1;

  // Phase length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd8;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  // Sequencer: next step, phase, counters and line drives for one tick.
  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    tick_d    = tick_q;
    bits_d    = bits_q;
    shift_d   = shift_q;
    bytes_d   = bytes_q;
    dev_d     = dev_q;
    reg_d     = reg_q;
    is_read_d = is_read_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    pend_d    = pend_q;
    enter_en  = 1'b0;
    enter_st  = STEP_IDLE;
    begin_en  = 1'b0;
    begin_ph  = ph_q + 2'd1;
    apply     = 1'b0;
    done      = 1'b0;
    rvalid    = 1'b0;
    rbyte     = 8'd0;
    stat      = STAT_OK;
    last      = phase_last(st_q, ph_q);

    unique case (st_q) inside
      STEP_IDLE: begin
        if (item_i.cmd == CMD_WRITE || item_i.cmd == CMD_READ) begin
          dev_d     = item_i.dev_addr;
          reg_d     = item_i.reg_addr;
          bytes_d   = item_i.byte_count;
          is_read_d = (item_i.cmd == CMD_READ);
          pend_d    = STAT_OK;
          enter_en  = 1'b1;
          enter_st  = STEP_START;
        end
      end
      STEP_NEED: begin
        if (item_i.cmd == CMD_SUPPLY) begin
          shift_d  = item_i.write_byte;
          enter_en = 1'b1;
          enter_st = STEP_DATA;
        end
      end
      default: begin
        tick_d = tick_inc;
        if (tick_inc >= limit) begin
          // Phase end: sample SDA and move on; default is the next phase.
          begin_en = 1'b1;
          unique case (st_q) inside
            STEP_START: begin
              if ((ph_q == 2'd0 && !item_i.sda_in) || (ph_q == 2'd1 && item_i.sda_in)) begin
                st_d     = STEP_IDLE;
                ph_d     = 2'd0;
                tick_d   = 16'd0;
                done     = 1'b1;
                stat     = STAT_BUS_BUSY;
                begin_en = 1'b0;
              end else if (last) begin
                shift_d  = dev_q;
                enter_en = 1'b1;
                enter_st = STEP_ADDR;
              end
            end
            STEP_RSTART: begin
              if (last) begin
                shift_d  = dev_q + 8'd1;
                enter_en = 1'b1;
                enter_st = STEP_RADDR;
              end
            end
            STEP_ADDR, STEP_REG, STEP_DATA, STEP_RADDR: begin
              if (last) begin
                bits_d = bits_inc;
                if (bits_inc[3]) begin
                  scl_d    = 1'b0;
                  enter_en = 1'b1;
                  unique case (st_q) inside
                    STEP_ADDR: enter_st = STEP_ADDR_ACK;
                    STEP_REG:  enter_st = STEP_REG_ACK;
                    STEP_DATA: enter_st = STEP_DATA_ACK;
                    default:   enter_st = STEP_RADDR_ACK;
                  endcase
                end else begin
                  begin_ph = 2'd0;
                end
              end
            end
            STEP_ADDR_ACK, STEP_REG_ACK, STEP_DATA_ACK, STEP_RADDR_ACK: begin
              if (last) begin
                scl_d    = 1'b0;
                enter_en = 1'b1;
                enter_st = STEP_STOP;
                unique case (st_q) inside
                  STEP_ADDR_ACK: begin
                    if (item_i.sda_in) begin
                      pend_d = STAT_ADDR_NACK;
                    end else begin
                      shift_d  = reg_q;
                      enter_st = STEP_REG;
                    end
                  end
                  STEP_REG_ACK: begin
                    if (is_read_q) begin
                      enter_st = STEP_RSTART;
                    end else if (bytes_q != 8'd0) begin
                      enter_en = 1'b0;
                      begin_en = 1'b0;
                      st_d     = STEP_NEED;
                      ph_d     = 2'd0;
                      tick_d   = 16'd0;
                    end
                  end
                  STEP_DATA_ACK: begin
                    if (item_i.sda_in) begin
                      pend_d = STAT_DATA_NACK;
                    end else begin
                      bytes_d = bytes_q - 8'd1;
                      if (bytes_q != 8'd1) begin
                        enter_en = 1'b0;
                        begin_en = 1'b0;
                        st_d     = STEP_NEED;
                        ph_d     = 2'd0;
                        tick_d   = 16'd0;
                      end
                    end
                  end
                  default: begin
                    if (bytes_q != 8'd0) begin
                      shift_d  = 8'd0;
                      enter_st = STEP_RECV;
                    end
                  end
                endcase
              end
            end
            STEP_RECV: begin
              if (last) begin
                shift_d = {shift_q[6:0], item_i.sda_in};
                bits_d  = bits_inc;
                if (bits_inc[3]) begin
                  scl_d    = 1'b0;
                  rvalid   = 1'b1;
                  rbyte    = shift_d;
                  enter_en = 1'b1;
                  enter_st = STEP_RACK;
                end else begin
                  begin_ph = 2'd0;
                end
              end
            end
            STEP_RACK: begin
              if (last) begin
                bytes_d  = bytes_q - 8'd1;
                enter_en = 1'b1;
                if (bytes_q == 8'd1) begin
                  enter_st = STEP_STOP;
                end else begin
                  shift_d  = 8'd0;
                  enter_st = STEP_RECV;
                end
              end
            end
            STEP_STOP: begin
              if (last) begin
                st_d     = STEP_IDLE;
                ph_d     = 2'd0;
                tick_d   = 16'd0;
                done     = 1'b1;
                stat     = pend_q;
                begin_en = 1'b0;
              end
            end
            default: begin
              begin_en = 1'b0;
            end
          endcase
        end
      end
    endcase

    // Start a new step or a new phase, then set the drives for it.
    if (enter_en) begin
      st_d   = enter_st;
      bits_d = 4'd0;
      ph_d   = 2'd0;
      tick_d = 16'd0;
      apply  = 1'b1;
    end else if (begin_en) begin
      ph_d   = begin_ph;
      tick_d = 16'd0;
      apply  = 1'b1;
    end
    drv = apply_phase(st_d, ph_d, shift_d, bytes_d, scl_d, sda_d);
    if (apply) begin
      scl_d   = drv.scl;
      sda_d   = drv.sda;
      shift_d = drv.shift;
    end
  end

  // Result word for this tick.
  always_comb begin
    res_d.scl_out    = scl_d;
    res_d.sda_out    = sda_d;
    res_d.read_byte  = rvalid ? rbyte : 8'd0;
    res_d.read_valid = rvalid;
    res_d.need_byte  = (st_d == STEP_NEED);
    res_d.busy_res   = (st_d != STEP_IDLE);
    res_d.done_res   = done;
    res_d.status     = stat;
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= STEP_IDLE;
      ph_q      <= 2'd0;
      tick_q    <= 16'd0;
      bits_q    <= 4'd0;
      shift_q   <= 8'd0;
      bytes_q   <= 8'd0;
      dev_q     <= 8'd0;
      reg_q     <= 8'd0;
      is_read_q <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      pend_q    <= STAT_OK;
    end else if (fire) begin
      st_q      <= st_d;
      ph_q      <= ph_d;
      tick_q    <= tick_d;
      bits_q    <= bits_d;
      shift_q   <= shift_d;
      bytes_q   <= bytes_d;
      dev_q     <= dev_d;
      reg_q     <= reg_d;
      is_read_q <= is_read_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      pend_q    <= pend_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.scl_out    = res_q.scl_out;
  assign res_o.sda_out    = res_q.sda_out;
  assign res_o.read_byte  = res_q.read_byte;
  assign res_o.read_valid = res_q.read_valid;
  assign res_o.need_byte  = res_q.need_byte;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.status     = res_q.status;

`ifndef NO_ASSERTIONS
  // Waiting for a data byte always lies inside a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.need_byte |-> res_q.busy_res)
    else $error("need_byte reported outside a transaction");

  // A finished transaction leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done reported while still busy");

  // A nonzero status only comes with the end of a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status != STAT_OK) |-> res_q.done_res)
    else $error("status reported without done");

  // The phase timer rests while idle or waiting for data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == STEP_IDLE || st_q == STEP_NEED) |-> (tick_q == 16'd0 && ph_q == 2'd0))
    else $error("phase timer running while stopped");
`endif

endmodule

// ===== hw/rtl/i2c_master_register_access_core.sv =====
// ----------------------------------------------------------------------------
// I2C master register access core
// Open-drain I2C master for register reads and writes, one bus tick per word.
// ----------------------------------------------------------------------------
// Flow: a request word waits in the two-entry queue and is run by the sequencer once the
// result register is free or being drained; its result word is then registered there.
// Throughput: one word per cycle while neither channel stalls; the two-entry queue and
// the output register let each channel stall on its own, and the sequencer runs a tick per word taken.
// Reset: phase length 8 ticks, both lines released, sequencer idle, queue empty.
module i2c_master_register_access_core
  import i2c_mra_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  i2c_mra_req_if.sink    req_i,
  i2c_mra_res_if.source  res_o
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Front end: accept and classify request words.
  i2c_mra_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Back end: bus sequencer and result register.
  i2c_mra_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_o        (res_o)
  );

endmodule

// ===== tb/i2c_mra_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master register access checker
// Watches the request and result channels and keeps its own model of the bus
// sequencer. Every request word taken by the core is turned into a predicted
// result word, and each result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_mra_checker
  import i2c_mra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  i2c_mra_req_if      req_mon_i,
  i2c_mra_res_if      res_mon_i,
  output int          fail_count_o,
  output int          pending_o,
  output step_e       bus_step_o,
  output logic        bus_sda_o
);

  // Model state of the bus sequencer.
  logic [15:0] phase_len;
  step_e       step_q;
  logic [1:0]  phase_q;
  logic [15:0] tick_q;
  logic [3:0]  bit_q;
  logic [7:0]  shift_q;
  logic [7:0]  left_q;
  logic [7:0]  dev_q;
  logic [7:0]  reg_q;
  logic        read_q;
  logic        scl_q;
  logic        sda_q;
  status_e     pend_q;

  // Predicted result words, oldest first.
  res_t tick_results[$];

  function automatic bit is_send_step(step_e s);
    return s == STEP_ADDR || s == STEP_REG || s == STEP_DATA || s == STEP_RADDR;
  endfunction

  function automatic bit is_ack_step(step_e s);
    return s == STEP_ADDR_ACK || s == STEP_REG_ACK || s == STEP_DATA_ACK ||
           s == STEP_RADDR_ACK;
  endfunction

  function automatic int phases_of(step_e s);
    if (s == STEP_RECV) return 2;
    if (s == STEP_RACK || s == STEP_STOP) return 4;
    return 3;
  endfunction

  task automatic reset_model();
    phase_len = 16'd8;
    step_q    = STEP_IDLE;
    phase_q   = 2'd0;
    tick_q    = 16'd0;
    bit_q     = 4'd0;
    shift_q   = 8'd0;
    left_q    = 8'd0;
    dev_q     = 8'd0;
    reg_q     = 8'd0;
    read_q    = 1'b0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    pend_q    = STAT_OK;
  endtask

  // Line drives set on the first tick of a phase.
  task automatic set_drives();
    case (step_q)
      STEP_START, STEP_RSTART: begin
        if (phase_q == 2'd0) begin
          sda_q = 1'b1;
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b0;
        end
      end
      STEP_ADDR, STEP_REG, STEP_DATA, STEP_RADDR: begin
        if (phase_q == 2'd0) begin
          scl_q = 1'b0;
        end else if (phase_q == 2'd1) begin
          sda_q   = shift_q[7];
          shift_q = {shift_q[6:0], 1'b0};
        end else begin
          scl_q = 1'b1;
        end
      end
      STEP_ADDR_ACK, STEP_REG_ACK, STEP_DATA_ACK, STEP_RADDR_ACK: begin
        if (phase_q == 2'd0) scl_q = 1'b0;
        else if (phase_q == 2'd1) sda_q = 1'b1;
        else scl_q = 1'b1;
      end
      STEP_RECV: begin
        if (phase_q == 2'd0) begin
          scl_q = 1'b0;
          sda_q = 1'b1;
        end else begin
          scl_q = 1'b1;
        end
      end
      STEP_RACK: begin
        if (phase_q == 2'd0) scl_q = 1'b0;
        else if (phase_q == 2'd1) sda_q = (left_q == 8'd1);
        else if (phase_q == 2'd2) scl_q = 1'b1;
        else scl_q = 1'b0;
      end
      STEP_STOP: begin
        if (phase_q == 2'd0) scl_q = 1'b0;
        else if (phase_q == 2'd1) sda_q = 1'b0;
        else if (phase_q == 2'd2) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  task automatic begin_phase(input logic [1:0] p);
    phase_q = p;
    tick_q  = 16'd0;
    set_drives();
  endtask

  task automatic enter_step(input step_e s);
    step_q = s;
    bit_q  = 4'd0;
    begin_phase(2'd0);
  endtask

  task automatic enter_with_byte(input step_e s, input logic [7:0] b);
    shift_q = b;
    enter_step(s);
  endtask

  // Waiting steps hold the lines and run no phase.
  task automatic park(input step_e s);
    step_q  = s;
    phase_q = 2'd0;
    tick_q  = 16'd0;
  endtask

  // End of a phase: sample SDA and move on.
  task automatic close_phase(input logic sda, output logic done, output logic rvalid,
                             output logic [7:0] rbyte, output status_e stat);
    bit last;
    done   = 1'b0;
    rvalid = 1'b0;
    rbyte  = 8'd0;
    stat   = STAT_OK;
    last   = (int'(phase_q) + 1 >= phases_of(step_q));
    if (step_q == STEP_START) begin
      // The line must be high before the start and fall during it.
      if ((phase_q == 2'd0 && !sda) || (phase_q == 2'd1 && sda)) begin
        park(STEP_IDLE);
        done = 1'b1;
        stat = STAT_BUS_BUSY;
        return;
      end
      if (last) begin
        enter_with_byte(STEP_ADDR, dev_q);
        return;
      end
    end else if (step_q == STEP_RSTART) begin
      if (last) begin
        enter_with_byte(STEP_RADDR, dev_q + 8'd1);
        return;
      end
    end else if (is_send_step(step_q)) begin
      if (last) begin
        bit_q = bit_q + 4'd1;
        if (bit_q >= 4'd8) begin
          scl_q = 1'b0;
          enter_step(step_e'(step_q + 4'd1));
        end else begin
          begin_phase(2'd0);
        end
        return;
      end
    end else if (is_ack_step(step_q)) begin
      if (last) begin
        scl_q = 1'b0;
        case (step_q)
          STEP_ADDR_ACK: begin
            if (sda) begin
              pend_q = STAT_ADDR_NACK;
              enter_step(STEP_STOP);
            end else begin
              enter_with_byte(STEP_REG, reg_q);
            end
          end
          STEP_REG_ACK: begin
            // The acknowledge of the register byte is not looked at.
            if (read_q) enter_step(STEP_RSTART);
            else if (left_q == 8'd0) enter_step(STEP_STOP);
            else park(STEP_NEED);
          end
          STEP_DATA_ACK: begin
            if (sda) begin
              pend_q = STAT_DATA_NACK;
              enter_step(STEP_STOP);
            end else begin
              left_q = left_q - 8'd1;
              if (left_q == 8'd0) enter_step(STEP_STOP);
              else park(STEP_NEED);
            end
          end
          default: begin
            if (left_q == 8'd0) begin
              enter_step(STEP_STOP);
            end else begin
              shift_q = 8'd0;
              enter_step(STEP_RECV);
            end
          end
        endcase
        return;
      end
    end else if (step_q == STEP_RECV) begin
      if (last) begin
        shift_q = {shift_q[6:0], sda};
        bit_q   = bit_q + 4'd1;
        if (bit_q >= 4'd8) begin
          scl_q  = 1'b0;
          rvalid = 1'b1;
          rbyte  = shift_q;
          enter_step(STEP_RACK);
        end else begin
          begin_phase(2'd0);
        end
        return;
      end
    end else if (step_q == STEP_RACK) begin
      if (last) begin
        left_q = left_q - 8'd1;
        if (left_q == 8'd0) begin
          enter_step(STEP_STOP);
        end else begin
          shift_q = 8'd0;
          enter_step(STEP_RECV);
        end
        return;
      end
    end else if (step_q == STEP_STOP) begin
      if (last) begin
        park(STEP_IDLE);
        done = 1'b1;
        stat = pend_q;
        return;
      end
    end
    begin_phase(phase_q + 2'd1);
  endtask

  // One bus tick: takes a request word, gives the result word it causes.
  task automatic run_bus_tick(input cmd_e cmd, input logic [7:0] dev, input logic [7:0] regi,
                              input logic [7:0] cnt, input logic [7:0] wbyte,
                              input logic sda, output res_t word);
    logic        done;
    logic        rvalid;
    logic [7:0]  rbyte;
    status_e     stat;
    logic [15:0] limit;
    done   = 1'b0;
    rvalid = 1'b0;
    rbyte  = 8'd0;
    stat   = STAT_OK;
    limit  = (phase_len == 16'd0) ? 16'd1 : phase_len;
    if (step_q == STEP_IDLE) begin
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
        dev_q  = dev;
        reg_q  = regi;
        left_q = cnt;
        read_q = (cmd == CMD_READ);
        pend_q = STAT_OK;
        enter_step(STEP_START);
      end
    end else if (step_q == STEP_NEED) begin
      if (cmd == CMD_SUPPLY) enter_with_byte(STEP_DATA, wbyte);
    end else begin
      tick_q = tick_q + 16'd1;
      if (tick_q >= limit) close_phase(sda, done, rvalid, rbyte, stat);
    end
    word.scl_out    = scl_q;
    word.sda_out    = sda_q;
    word.read_byte  = rvalid ? rbyte : 8'd0;
    word.read_valid = rvalid;
    word.need_byte  = (step_q == STEP_NEED);
    word.busy_res   = (step_q != STEP_IDLE);
    word.done_res   = done;
    word.status     = stat;
  endtask

  // Track configuration, predict on each request word, compare each result word.
  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t want;
    res_t got;
    if (!rst_ni) begin
      reset_model();
      tick_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) phase_len = cfg_wdata_i;
      if (req_mon_i.valid && req_mon_i.ready) begin
        run_bus_tick(cmd_e'(req_mon_i.req_type), req_mon_i.dev_addr, req_mon_i.reg_addr,
                     req_mon_i.byte_count, req_mon_i.write_byte, req_mon_i.sda_in, want);
        tick_results.push_back(want);
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        got.scl_out    = res_mon_i.scl_out;
        got.sda_out    = res_mon_i.sda_out;
        got.read_byte  = res_mon_i.read_byte;
        got.read_valid = res_mon_i.read_valid;
        got.need_byte  = res_mon_i.need_byte;
        got.busy_res   = res_mon_i.busy_res;
        got.done_res   = res_mon_i.done_res;
        got.status     = status_e'(res_mon_i.status);
        if (tick_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("result word with no request outstanding at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = tick_results.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display({"result mismatch at %0t: want scl=%b sda=%b rbyte=%h rv=%b need=%b ",
                        "busy=%b done=%b stat=%0d, got scl=%b sda=%b rbyte=%h rv=%b need=%b ",
                        "busy=%b done=%b stat=%0d"}, $realtime,
                       want.scl_out, want.sda_out, want.read_byte, want.read_valid,
                       want.need_byte, want.busy_res, want.done_res, want.status,
                       got.scl_out, got.sda_out, got.read_byte, got.read_valid,
                       got.need_byte, got.busy_res, got.done_res, got.status);
            fail_count_o++;
          end
        end
      end
    end
    pending_o  = tick_results.size();
    bus_step_o = step_q;
    bus_sda_o  = sda_q;
  end

endmodule

// ===== tb/i2c_master_register_access_core_test.sv =====
// ----------------------------------------------------------------------------
// I2C master register access core test
// Drives bus ticks into the core with a simple device model on SDA: directed
// writes, reads, acknowledge failures and failed starts at several phase
// lengths, then random transfers with stray words. Both channels stall at
// random; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core_test;
  import i2c_mra_pkg::*;

  // How the device side answers on SDA.
  typedef enum logic [2:0] {
    LINE_NORMAL,
    LINE_ACK_ALL,
    LINE_NACK_ADDR,
    LINE_NACK_DATA,
    LINE_HELD_LOW,
    LINE_HELD_HIGH
  } line_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  step_e       bus_step;
  logic        bus_sda;

  line_mode_e  line_mode;
  int          work_items;
  int          pause_at;
  bit          req_steady;
  bit          res_steady;

  i2c_mra_req_if req_ch ();
  i2c_mra_res_if res_ch ();

  i2c_master_register_access_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  i2c_mra_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon_i    (req_ch),
    .res_mon_i    (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bus_step_o   (bus_step),
    .bus_sda_o    (bus_sda)
  );

  // Clock, period 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones, and stretches with none.
  function automatic int pick_gap(inout bit steady);
    int r;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 15);
    if (r < 6) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // SDA level seen on the bus: the master's drive plus the device.
  function automatic logic device_sda(step_e s, logic master);
    logic v;
    v = master;
    case (s)
      STEP_IDLE: v = 1'($urandom_range(0, 1));
      STEP_START: begin
        // Rare glitch, so a normal run sometimes finds the bus busy.
        if (line_mode == LINE_NORMAL && $urandom_range(0, 63) == 0) v = !master;
      end
      STEP_ADDR_ACK:
        v = (line_mode == LINE_NACK_ADDR) ||
            (line_mode == LINE_NORMAL && $urandom_range(0, 15) == 0);
      STEP_DATA_ACK:
        v = (line_mode == LINE_NACK_DATA) ||
            (line_mode == LINE_NORMAL && $urandom_range(0, 15) == 0);
      STEP_REG_ACK, STEP_RADDR_ACK, STEP_RECV: v = 1'($urandom_range(0, 1));
      default: begin
      end
    endcase
    if (line_mode == LINE_HELD_LOW) v = 1'b0;
    else if (line_mode == LINE_HELD_HIGH) v = 1'b1;
    return v;
  endfunction

  // Offer one request word and wait until it is taken. Starts and ends at a
  // falling edge, so the next word follows without a dead cycle.
  task automatic send_word(input cmd_e cmd, input logic [7:0] dev, input logic [7:0] regi,
                           input logic [7:0] cnt, input logic [7:0] wbyte);
    int gap;
    gap = pick_gap(req_steady);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (!((bus_step == STEP_IDLE && cmd != CMD_WRITE && cmd != CMD_READ) ||
          (bus_step == STEP_NEED && cmd != CMD_SUPPLY)))
      work_items++;
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= cmd;
    req_ch.dev_addr   <= dev;
    req_ch.reg_addr   <= regi;
    req_ch.byte_count <= cnt;
    req_ch.write_byte <= wbyte;
    req_ch.sda_in     <= device_sda(bus_step, bus_sda);
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted result word has arrived.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_phase_len(input logic [15:0] value);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One transfer from its begin word until the sequencer is idle again.
  task automatic run_transfer(input cmd_e cmd, input logic [7:0] dev, input logic [7:0] regi,
                              input logic [7:0] cnt, input line_mode_e mode, input bit noisy);
    cmd_e pick;
    line_mode = mode;
    send_word(cmd, dev, regi, cnt, 8'($urandom_range(0, 255)));
    while (bus_step != STEP_IDLE) begin
      if (work_items == pause_at) begin
        pause_at = -1;
        drain();
      end
      if (bus_step == STEP_NEED) begin
        // The byte is sometimes late; the core must hold the lines.
        if ($urandom_range(0, 7) == 0) pick = noisy ? cmd_e'($urandom_range(0, 2)) : CMD_TICK;
        else pick = CMD_SUPPLY;
      end else if (noisy && $urandom_range(0, 15) == 0) begin
        pick = cmd_e'($urandom_range(1, 3));
      end else begin
        pick = CMD_TICK;
      end
      send_word(pick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    line_mode = LINE_NORMAL;
  endtask

  task automatic random_transfer();
    cmd_e       cmd;
    logic [7:0] cnt;
    // Words at idle that start nothing.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_word($urandom_range(0, 1) ? CMD_SUPPLY : CMD_TICK, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    cnt = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(4, 6)) : 8'($urandom_range(0, 3));
    run_transfer(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cnt,
                 LINE_NORMAL, 1'b1);
  endtask

  // Result side: ready drops for random stretches.
  initial begin : res_pacer
    int gap;
    res_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      gap = pick_gap(res_steady);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int        seg_start;
    logic [15:0] seg_len [2];
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 16'd0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = CMD_TICK;
    req_ch.dev_addr   = 8'd0;
    req_ch.reg_addr   = 8'd0;
    req_ch.byte_count = 8'd0;
    req_ch.write_byte = 8'd0;
    req_ch.sda_in     = 1'b1;
    line_mode         = LINE_NORMAL;
    work_items        = 0;
    pause_at          = -1;
    req_steady        = 1'b0;
    res_steady        = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the default phase length shows in a start that fails at its
    // first sample, with the line low before the start.
    run_transfer(CMD_WRITE, 8'hA0, 8'h10, 8'd1, LINE_HELD_LOW, 1'b0);
    set_phase_len(16'd1);
    // Read address wraps from 0xFF to 0x00.
    run_transfer(CMD_READ, 8'hFF, 8'h00, 8'd0, LINE_ACK_ALL, 1'b0);
    run_transfer(CMD_WRITE, 8'h44, 8'h03, 8'd3, LINE_NACK_DATA, 1'b0);
    // Failed start: the line does not fall during the start.
    run_transfer(CMD_READ, 8'h48, 8'h05, 8'd1, LINE_HELD_HIGH, 1'b0);
    // A zero phase length behaves as one tick.
    set_phase_len(16'd0);
    run_transfer(CMD_WRITE, 8'h42, 8'h01, 8'd2, LINE_NACK_ADDR, 1'b0);

    // Random transfers in segments at two phase lengths.
    seg_len[0] = 16'd1;
    seg_len[1] = 16'd2;
    for (int seg = 0; seg < 2; seg++) begin
      set_phase_len(seg_len[seg]);
      seg_start = work_items;
      pause_at  = work_items + int'($urandom_range(20, 60));
      while (work_items < seg_start + 80) random_transfer();
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
